@@ design/itaf_pkg.sv @@
package itaf_pkg;

    localparam int VALUE_PORT_W       = 64;
    localparam int DEF_VALUE_WIDTH    = 64;
    localparam int DEF_MAX_HEX_DIGITS = 16;

    localparam logic [1:0] OP_SDEC    = 2'd0;
    localparam logic [1:0] OP_UDEC    = 2'd1;
    localparam logic [1:0] OP_HEX     = 2'd2;
    localparam int         OP_HEX_BIT = 1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOWA  = 8'h61;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] RADIX    = 8'd10;
    localparam logic [3:0] DIG_MAX  = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_CONV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_dab_ctrl;

    // decimal digits of 2**w - 1 (1233/4096 ~ log10 2)
    function automatic int dec_digits(input int w);
        return ((w * 1233) >> 12) + 1;
    endfunction

endpackage

@@ design/itaf_dabble.sv @@
module itaf_dabble #(
    parameter int VALUE_WIDTH = 64,
    parameter int DEC_DIGITS  = 20
) (
    input  logic                      i_clk,
    input  itaf_pkg::t_dab_ctrl       i_ctrl,
    input  logic [VALUE_WIDTH-1:0]    i_value,
    output logic [VALUE_WIDTH-1:0]    o_bin,
    output logic [4*DEC_DIGITS-1:0]   o_bcd
);
    import itaf_pkg::*;

    localparam int BCD_W = 4 * DEC_DIGITS;

    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [BCD_W-1:0]       w_adj;

    // add-3 on every digit of 5 or more, then shift one binary bit in
    always_comb begin
        for (int k = 0; k < DEC_DIGITS; k++) begin
            w_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? (r_bcd[4*k +: 4] + 4'd3)
                                                        : r_bcd[4*k +: 4];
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_ctrl.load) begin
            n_bin = i_value;
            n_bcd = '0;
        end else if (i_ctrl.step) begin
            {n_bcd, n_bin} = {w_adj, r_bin} << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_bin = r_bin;
    assign o_bcd = r_bcd;

endmodule

@@ design/integer_to_ascii_formatter.sv @@
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+------------------------------------------
// in      | input     | i_valid / o_ready  | i_value i_opcode i_digit_count
//         |           |                    | i_upper_case i_pad_char
// out     | output    | o_valid / i_ready  | o_char_out o_last
//
// Hex: the beat is taken, then each nibble position (1..MAX_HEX_DIGITS) in turn, most significant first.
// Decimal: the beat is taken, a '-' is sent for a negative value, VALUE_WIDTH double-dabble
// shifts follow, then each BCD position in turn (20 for 64 bits).
// Synchronous active-low reset clears the sequencer and the output valid.
// A stalled output holds the sequencer on the pending character; dropped positions
// still advance.
module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH    = itaf_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_HEX_DIGITS = itaf_pkg::DEF_MAX_HEX_DIGITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [itaf_pkg::VALUE_PORT_W-1:0] i_value,
    input  logic [1:0]                        i_opcode,
    input  logic [4:0]                        i_digit_count,
    input  logic                              i_upper_case,
    input  logic [7:0]                        i_pad_char,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [7:0]                        o_char_out,
    output logic                              o_last
);
    import itaf_pkg::*;

    localparam int DEC_DIGITS = dec_digits(VALUE_WIDTH);
    localparam int HEX_W      = 4 * MAX_HEX_DIGITS;
    localparam int IDX_N      = (DEC_DIGITS > MAX_HEX_DIGITS) ? DEC_DIGITS : MAX_HEX_DIGITS;
    localparam int IDX_W      = $clog2(IDX_N);
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

    t_state                  r_state, n_state;
    logic                    r_out_valid, n_out_valid;
    logic [7:0]              r_char, n_char;
    logic                    r_last, n_last;
    logic                    r_hex, n_hex;
    logic                    r_upper, n_upper;
    logic [7:0]              r_pad, n_pad;
    logic                    r_lead, n_lead;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_cnt, n_cnt;

    t_dab_ctrl               w_ctrl;
    logic [VALUE_WIDTH-1:0]  w_v, w_mag, w_bin;
    logic [4*DEC_DIGITS-1:0] w_bcd;
    logic [HEX_W-1:0]        w_hex_word;
    logic                    w_accept, w_free, w_neg;
    logic                    w_lead_now, w_emit, w_adv;
    logic [4:0]              w_ndig, w_ndig_m1;
    logic [3:0]              w_nib;
    logic [7:0]              w_letter, w_char;

    itaf_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DEC_DIGITS  (DEC_DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_value (w_mag),
        .o_bin   (w_bin),
        .o_bcd   (w_bcd)
    );

    generate
        if (VALUE_WIDTH >= HEX_W) begin : g_hex_trunc
            assign w_hex_word = w_bin[HEX_W-1:0];
        end else begin : g_hex_ext
            assign w_hex_word = {{(HEX_W - VALUE_WIDTH){1'b0}}, w_bin};
        end
    endgenerate

    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_free     = !r_out_valid || i_ready;

    assign w_v        = i_value[VALUE_WIDTH-1:0];
    assign w_neg      = (i_opcode == OP_SDEC) && w_v[VALUE_WIDTH-1];
    assign w_mag      = w_neg ? (~w_v + 1'b1) : w_v;

    always_comb begin
        if (i_digit_count == 5'd0) begin
            w_ndig = 5'd1;
        end else if (i_digit_count > 5'(MAX_HEX_DIGITS)) begin
            w_ndig = 5'(MAX_HEX_DIGITS);
        end else begin
            w_ndig = i_digit_count;
        end
    end
    assign w_ndig_m1  = w_ndig - 5'd1;

    assign w_nib      = r_hex ? w_hex_word[4*r_idx +: 4] : w_bcd[4*r_idx +: 4];
    assign w_lead_now = r_lead && (w_nib == 4'd0) && (r_idx != '0);
    assign w_emit     = !w_lead_now || (r_hex && (r_pad != 8'd0));
    assign w_adv      = !w_emit || w_free;
    assign w_letter   = r_upper ? CH_UPA : CH_LOWA;

    always_comb begin
        if (w_lead_now) begin
            w_char = r_pad;
        end else if (w_nib > DIG_MAX) begin
            w_char = w_letter + {4'b0, w_nib} - RADIX;
        end else begin
            w_char = CH_ZERO + {4'b0, w_nib};
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_opcode[OP_HEX_BIT]) begin
                        n_state = ST_EMIT;
                    end else if (w_neg) begin
                        n_state = ST_SIGN;
                    end else begin
                        n_state = ST_CONV;
                    end
                end
            end
            ST_SIGN: begin
                if (w_free) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_cnt == CNT_W'(VALUE_WIDTH - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_adv && (r_idx == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_char      = r_char;
        n_last      = r_last;
        n_hex       = r_hex;
        n_upper     = r_upper;
        n_pad       = r_pad;
        n_lead      = r_lead;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        w_ctrl      = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_ctrl.load = 1'b1;
                    n_hex       = i_opcode[OP_HEX_BIT];
                    n_upper     = i_upper_case;
                    n_pad       = i_pad_char;
                    n_lead      = 1'b1;
                    n_cnt       = '0;
                    n_idx       = i_opcode[OP_HEX_BIT] ? w_ndig_m1[IDX_W-1:0]
                                                       : IDX_W'(DEC_DIGITS - 1);
                end
            end
            ST_SIGN: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_MINUS;
                    n_last      = 1'b0;
                end
            end
            ST_CONV: begin
                w_ctrl.step = 1'b1;
                n_cnt       = r_cnt + 1'b1;
            end
            ST_EMIT: begin
                if (w_adv) begin
                    n_idx  = r_idx - 1'b1;
                    n_lead = w_lead_now;
                    if (w_emit) begin
                        n_out_valid = 1'b1;
                        n_char      = w_char;
                        n_last      = (r_idx == '0);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_last  <= n_last;
        r_hex   <= n_hex;
        r_upper <= n_upper;
        r_pad   <= n_pad;
        r_lead  <= n_lead;
        r_idx   <= n_idx;
        r_cnt   <= n_cnt;
    end

    assign o_valid    = r_out_valid;
    assign o_char_out = r_char;
    assign o_last     = r_last;

    a_conv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> (r_cnt < CNT_W'(VALUE_WIDTH)))
        else $error("shift count past value width");

    a_final_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_idx == '0 && w_free)
            |=> (r_state == ST_IDLE && o_valid && o_last))
        else $error("final position did not close the number");

    a_hex_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_opcode[OP_HEX_BIT]) |=> (r_state == ST_EMIT && r_hex))
        else $error("hex beat did not go straight to emission");

    a_hex_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_hex) |-> (32'(r_idx) < MAX_HEX_DIGITS))
        else $error("hex position out of range");

endmodule
